/* hw/rtl/i2cmws_pkg.sv */
package i2cmws_pkg;

    localparam int BYTE_W    = 8;
    localparam int BIT_IDX_W = $clog2(BYTE_W);
    localparam int NUM_STEPS = 5;
    localparam int PC_W      = $clog2(NUM_STEPS);
    localparam int BIT_CNT_W = $clog2(BYTE_W + 1);

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [PC_W-1:0]      pc_t;
    typedef logic [NUM_STEPS-1:0] step_mask_t;
    typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

    // bus symbol codes as seen by the line driver
    typedef enum logic [1:0] {
        SYM_START = 2'd0,
        SYM_DATA  = 2'd1,
        SYM_ACK   = 2'd2,
        SYM_STOP  = 2'd3
    } sym_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_BYTE,
        OP_STOP
    } op_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_ADDR,
        SRC_CMD,
        SRC_PAYLOAD
    } src_t;

    typedef enum logic [1:0] {
        COND_FIRST,
        COND_DATA,
        COND_LAST
    } cond_t;

    typedef struct packed {
        op_t   op;
        src_t  src;
        cond_t cond;
    } ctl_word_t;

    // microprogram: one step per bus phrase, each guarded by an item flag
    function automatic ctl_word_t ucode_rom(input pc_t step);
        ctl_word_t w;
        case (step)
            pc_t'(0): w = '{op: OP_START, src: SRC_NONE,    cond: COND_FIRST};
            pc_t'(1): w = '{op: OP_BYTE,  src: SRC_ADDR,    cond: COND_FIRST};
            pc_t'(2): w = '{op: OP_BYTE,  src: SRC_CMD,     cond: COND_FIRST};
            pc_t'(3): w = '{op: OP_BYTE,  src: SRC_PAYLOAD, cond: COND_DATA};
            pc_t'(4): w = '{op: OP_STOP,  src: SRC_NONE,    cond: COND_LAST};
            default:  w = '{op: OP_STOP,  src: SRC_NONE,    cond: COND_LAST};
        endcase
        return w;
    endfunction

    // lowest pending step, used as the conditional jump target
    function automatic pc_t first_step(input step_mask_t mask);
        pc_t p;
        p = '0;
        for (int i = NUM_STEPS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                p = pc_t'(i);
            end
        end
        return p;
    endfunction

endpackage

/* hw/rtl/i2c_master_write_serializer.sv */
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: command, payload; tuser: has_data, first
//                                                tlast: last
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: bit_value; tuser: symbol_kind
//                                                tlast: end_of_run
// cfg       in   cfg_we                          cfg_wdata: slave_address
//
// one bus symbol per cycle from the microcode sequencer while the output register is not stalled
// the step counter and bit counter walk the program; the next item is taken once the final
// symbol sits in the output register
// rst_n clears the sequencer, output valid and the address register; no clearing pass
// a stalled output register freezes the sequencer
module i2c_master_write_serializer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,       // slave_address
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [7:0] command_byte, [15:8] payload_byte
    input  logic [1:0]  s_axis_tuser,    // [0] has_data, [1] first
    input  logic        s_axis_tlast,    // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [0] bit_value, [7:1] zero
    output logic [1:0]  m_axis_tuser,    // [1:0] symbol_kind
    output logic        m_axis_tlast     // end_of_run
);
    import i2cmws_pkg::*;

    byte_t      addr_reg;
    byte_t      cmd_reg, cmd_next;
    byte_t      payload_reg, payload_next;
    logic       busy_reg, busy_next;
    pc_t        pc_reg, pc_next;
    bit_cnt_t   bit_cnt_reg, bit_cnt_next;
    step_mask_t pend_reg, pend_next;

    logic       out_valid_reg, out_valid_next;
    sym_t       out_kind_reg, out_kind_next;
    logic       out_bit_reg, out_bit_next;
    logic       out_last_reg, out_last_next;

    ctl_word_t  cw;
    ctl_word_t  step_w;
    step_mask_t item_mask;
    step_mask_t rest_mask;
    byte_t      sel_byte;
    logic       adv;
    logic       step_done;
    logic       in_accept;

    always_comb
    begin
        step_w = '0;
        for (int i = 0; i < NUM_STEPS; i++)
        begin
            step_w = ucode_rom(pc_t'(i));
            case (step_w.cond)
                COND_FIRST: item_mask[i] = s_axis_tuser[1];
                COND_DATA:  item_mask[i] = s_axis_tuser[0];
                COND_LAST:  item_mask[i] = s_axis_tlast;
                default:    item_mask[i] = 1'b0;
            endcase
        end
    end

    assign cw            = ucode_rom(pc_reg);
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !busy_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        case (cw.src)
            SRC_ADDR:    sel_byte = addr_reg;
            SRC_CMD:     sel_byte = cmd_reg;
            SRC_PAYLOAD: sel_byte = payload_reg;
            default:     sel_byte = '0;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        bit_cnt_next   = bit_cnt_reg;
        pend_next      = pend_reg;
        cmd_next       = cmd_reg;
        payload_next   = payload_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_bit_next   = out_bit_reg;
        out_last_next  = out_last_reg;
        step_done      = 1'b0;
        rest_mask      = pend_reg & ~(step_mask_t'(1) << pc_reg);

        if (in_accept)
        begin
            cmd_next     = s_axis_tdata[7:0];
            payload_next = s_axis_tdata[15:8];
            pend_next    = item_mask;
            pc_next      = first_step(item_mask);
            bit_cnt_next = '0;
            busy_next    = |item_mask;
        end
        else if (busy_reg && adv)
        begin
            out_valid_next = 1'b1;
            out_bit_next   = 1'b0;
            case (cw.op)
                OP_START:
                begin
                    out_kind_next = SYM_START;
                    step_done     = 1'b1;
                end
                OP_BYTE:
                begin
                    if (bit_cnt_reg < bit_cnt_t'(BYTE_W))
                    begin
                        out_kind_next = SYM_DATA;
                        // msb first
                        out_bit_next  = sel_byte[~bit_cnt_reg[BIT_IDX_W-1:0]];
                        bit_cnt_next  = bit_cnt_reg + bit_cnt_t'(1);
                    end
                    else
                    begin
                        out_kind_next = SYM_ACK;
                        step_done     = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    out_kind_next = SYM_STOP;
                    step_done     = 1'b1;
                end
                default:
                begin
                    out_kind_next = SYM_STOP;
                    step_done     = 1'b1;
                end
            endcase
            out_last_next = step_done && (rest_mask == '0);
            if (step_done)
            begin
                pend_next    = rest_mask;
                pc_next      = first_step(rest_mask);
                bit_cnt_next = '0;
                busy_next    = |rest_mask;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            bit_cnt_reg   <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                addr_reg <= cfg_wdata;
            end
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            bit_cnt_reg   <= bit_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        payload_reg  <= payload_next;
        out_kind_reg <= out_kind_next;
        out_bit_reg  <= out_bit_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_bit_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // step counter always points at a pending step while busy
    a_pc_pending: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pend_reg[pc_reg])
        else $error("step counter on a step that is not pending");

    a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (cw.op != OP_BYTE) |-> bit_cnt_reg == '0)
        else $error("bit counter running outside a byte step");

    a_bit_only_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_kind_reg != SYM_DATA) |-> !out_bit_reg)
        else $error("sda level set on a non-data symbol");

    // the closing symbol of an item frees the input side
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && adv && step_done && (rest_mask == '0) |=> !busy_reg && out_last_reg)
        else $error("final symbol did not release the sequencer");

endmodule

/* tb/tb_i2c_master_write_serializer.sv */
`timescale 1ns / 100ps

module tb_i2c_master_write_serializer;

    import i2cmws_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        sym_t        kind;
        logic [7:0]  level_byte;
        logic        run_end;
    } bus_symbol_t;

    class symbol_scoreboard;
        bus_symbol_t expected_symbols[$];
        logic [7:0]  slave_address;
        int          errors;
        int          symbols_checked;
        int          items_noted;

        function new();
            slave_address   = '0;
            errors          = 0;
            symbols_checked = 0;
            items_noted     = 0;
        endfunction

        function void set_address(input logic [7:0] value);
            slave_address = value;
        endfunction

        function int pending();
            return expected_symbols.size();
        endfunction

        function void push_symbol(input sym_t kind, input logic level);
            bus_symbol_t s;
            s.kind       = kind;
            s.level_byte = {7'b0, level};
            s.run_end    = 1'b0;
            expected_symbols.push_back(s);
        endfunction

        // eight data bits msb first, then the ack slot whatever the slave answers
        function void push_byte(input logic [7:0] value);
            for (int i = 7; i >= 0; i--)
            begin
                push_symbol(SYM_DATA, value[i]);
            end
            push_symbol(SYM_ACK, 1'b0);
        endfunction

        function void queue_item_symbols(input logic [7:0] command_byte,
                                         input logic [7:0] payload_byte,
                                         input logic has_data, input logic first,
                                         input logic last);
            int start_size;
            start_size = expected_symbols.size();
            if (first)
            begin
                push_symbol(SYM_START, 1'b0);
                push_byte(slave_address);
                push_byte(command_byte);
            end
            if (has_data)
            begin
                push_byte(payload_byte);
            end
            if (last)
            begin
                push_symbol(SYM_STOP, 1'b0);
            end
            if (expected_symbols.size() > start_size)
            begin
                expected_symbols[expected_symbols.size() - 1].run_end = 1'b1;
                items_noted++;
            end
        endfunction

        function void check_symbol(input sym_t kind, input logic [7:0] level_byte,
                                   input logic run_end);
            bus_symbol_t want;
            symbols_checked++;
            if (expected_symbols.size() == 0)
            begin
                errors++;
                $display("%0t: symbol with nothing expected: kind %0d data %h last %b",
                         $time, kind, level_byte, run_end);
                return;
            end
            want = expected_symbols.pop_front();
            if (want.kind !== kind)
            begin
                errors++;
                $display("%0t: symbol kind expected %0d actual %0d", $time, want.kind, kind);
            end
            if (want.level_byte !== level_byte)
            begin
                errors++;
                $display("%0t: symbol data expected %h actual %h",
                         $time, want.level_byte, level_byte);
            end
            if (want.run_end !== run_end)
            begin
                errors++;
                $display("%0t: end of run expected %b actual %b", $time, want.run_end, run_end);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [7:0] command_byte, [15:8] payload_byte
    logic [1:0]  s_axis_tuser;    // [0] has_data, [1] first
    logic        s_axis_tlast;    // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // [0] bit_value, [7:1] zero
    logic [1:0]  m_axis_tuser;    // [1:0] symbol_kind
    logic        m_axis_tlast;    // end_of_run

    symbol_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    int  hold_left;
    int  cycle_count;
    int  address_writes;
    int  transactions;

    i2c_master_write_serializer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL i2c_master_write_serializer");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            board.check_symbol(sym_t'(m_axis_tuser), m_axis_tdata, m_axis_tlast);
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input logic [7:0] command_byte, input logic [7:0] payload_byte,
                             input logic has_data, input logic first, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {payload_byte, command_byte};
        s_axis_tuser  <= {first, has_data};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.queue_item_symbols(command_byte, payload_byte, has_data, first, last);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
        // settling wait after the last expected symbol has arrived
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_slave_address(input logic [7:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_address(value);
        address_writes++;
        @(negedge clk);
    endtask

    task automatic random_transaction();
        int  len;
        logic has_data;
        len = $urandom_range(1, 4);
        transactions++;
        for (int k = 0; k < len; k++)
        begin
            has_data = (k == 0) ? ($urandom_range(3) != 0) : 1'b1;
            send_item(8'($urandom), 8'($urandom), has_data, k == 0, k == len - 1);
        end
    endtask

    task automatic run_random_phase(input int target);
        int start_count;
        start_count = board.items_noted;
        while (board.items_noted - start_count < target)
        begin
            if ($urandom_range(99) < 20)
            begin
                send_item(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom));
            end
            else
            begin
                random_transaction();
            end
        end
    endtask

    initial
    begin
        board          = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        hold_req       = 1'b0;
        hold_left      = 0;
        cycle_count    = 0;
        address_writes = 0;
        transactions   = 0;
        send_idle_pct  = 22;
        recv_idle_pct  = 62;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // address still at its reset value
        send_item(8'h00, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_item(8'hFF, 8'h00, 1'b1, 1'b1, 1'b1);
        set_slave_address(8'hFF);
        send_item(8'hA5, 8'h5A, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 8'h80, 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 8'h01, 1'b1, 1'b0, 1'b1);
        // empty transfer: header and stop only
        send_item(8'h3C, 8'h00, 1'b0, 1'b1, 1'b1);
        // nothing to send, then a lone stop
        send_item(8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0);
        send_item(8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        // continuation with no start before it
        send_item(8'hC3, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_item(8'h7E, 8'h00, 1'b0, 1'b1, 1'b0);
        send_item(8'h81, 8'h00, 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_item(8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_item(8'h01, 8'h7F, 1'b1, 1'b1, 1'b1);

        set_slave_address(8'($urandom));
        // receiver holds off while items keep coming, so the input stalls
        hold_req = 1'b1;
        run_random_phase(80);

        set_slave_address(8'h00);
        send_idle_pct = 62;
        recv_idle_pct = 22;
        run_random_phase(80);

        set_slave_address(8'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(35);
        wait_drained();
        run_random_phase(35);

        wait_drained();
        if (board.pending() != 0)
        begin
            board.errors++;
            $display("%0t: %0d symbols never arrived", $time, board.pending());
        end
        $display("run covered %0d items in %0d random transactions, %0d bus symbols,",
                 board.items_noted, transactions, board.symbols_checked);
        $display("%0d address settings, stalls on both sides and a long output hold-off",
                 address_writes);
        if (board.errors == 0)
        begin
            $display("PASS i2c_master_write_serializer");
        end
        else
        begin
            $display("FAIL i2c_master_write_serializer");
        end
        $finish;
    end

endmodule
